### rtl/csb_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// csb_pkg
// Shared widths, operation codes and lane status type for the RGB contrast
// stretch block.
// ---------------------------------------------------------------------------
package csb_pkg;

  localparam int PIX_W   = 8;
  localparam int NUM_W   = 2 * PIX_W;
  localparam int CNT_W   = $clog2(PIX_W + 1);
  localparam int NLANES  = 3;

  localparam logic FUNC_MEASURE = 1'b0;
  localparam logic FUNC_APPLY   = 1'b1;

  typedef logic [PIX_W-1:0] pix_t;

  typedef struct packed {
    logic busy;
    logic done;
  } lane_stat_t;

endpackage

### rtl/csb_lane.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// csb_lane
// One color channel: tracks the channel minimum and maximum, and stretches a
// value with a restoring divider that resolves one quotient bit per cycle.
// ---------------------------------------------------------------------------
module csb_lane (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                measure,
  input  logic                first,
  input  logic                start,
  input  logic                ack,
  input  csb_pkg::pix_t       pix,
  output csb_pkg::lane_stat_t stat,
  output csb_pkg::pix_t       quot
);

  csb_pkg::pix_t lo_r, lo_nxt;
  csb_pkg::pix_t hi_r, hi_nxt;
  csb_pkg::pix_t span_r, span_nxt;
  csb_pkg::pix_t rem_r, rem_nxt;
  csb_pkg::pix_t nq_r, nq_nxt;
  logic          zero_r, zero_nxt;
  logic          busy_r, busy_nxt;
  logic [csb_pkg::CNT_W-1:0] cnt_r, cnt_nxt;

  csb_pkg::pix_t                vc;
  csb_pkg::pix_t                dlt;
  logic [csb_pkg::NUM_W-1:0]    num;
  logic [csb_pkg::PIX_W:0]      trial;
  logic                         qbit;

  always_comb begin
    if (pix < lo_r) begin
      vc = lo_r;
    end else if (pix > hi_r) begin
      vc = hi_r;
    end else begin
      vc = pix;
    end
    dlt   = vc - lo_r;
    // times full scale: (d << W) - d
    num   = {dlt, {csb_pkg::PIX_W{1'b0}}} - {{csb_pkg::PIX_W{1'b0}}, dlt};
    trial = {rem_r, nq_r[csb_pkg::PIX_W-1]};
    qbit  = (trial >= {1'b0, span_r});
  end

  always_comb begin
    lo_nxt   = lo_r;
    hi_nxt   = hi_r;
    span_nxt = span_r;
    rem_nxt  = rem_r;
    nq_nxt   = nq_r;
    zero_nxt = zero_r;
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    if (measure) begin
      if (first) begin
        lo_nxt = pix;
        hi_nxt = pix;
      end else begin
        if (pix < lo_r) begin
          lo_nxt = pix;
        end
        if (pix > hi_r) begin
          hi_nxt = pix;
        end
      end
    end
    if (busy_r && (cnt_r != '0)) begin
      cnt_nxt = cnt_r - 1'b1;
      nq_nxt  = {nq_r[csb_pkg::PIX_W-2:0], qbit};
      if (qbit) begin
        rem_nxt = csb_pkg::PIX_W'(trial - {1'b0, span_r});
      end else begin
        rem_nxt = trial[csb_pkg::PIX_W-1:0];
      end
    end
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = csb_pkg::CNT_W'(csb_pkg::PIX_W);
      span_nxt = hi_r - lo_r;
      zero_nxt = (hi_r <= lo_r);
      rem_nxt  = num[csb_pkg::NUM_W-1:csb_pkg::PIX_W];
      nq_nxt   = num[csb_pkg::PIX_W-1:0];
    end else if (ack) begin
      busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lo_r   <= '0;
      hi_r   <= '0;
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      lo_r   <= lo_nxt;
      hi_r   <= hi_nxt;
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    span_r <= span_nxt;
    rem_r  <= rem_nxt;
    nq_r   <= nq_nxt;
    zero_r <= zero_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = busy_r && (cnt_r == '0);
  assign quot      = zero_r ? '0 : nq_r;

endmodule

### rtl/csb_merge.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// csb_merge
// Joins the three lane quotients into one result request and holds it in the
// output register until the downstream side takes it.
// ---------------------------------------------------------------------------
module csb_merge (
  input  logic                clk,
  input  logic                rst_n,
  input  csb_pkg::lane_stat_t stat_r_l,
  input  csb_pkg::lane_stat_t stat_g_l,
  input  csb_pkg::lane_stat_t stat_b_l,
  input  csb_pkg::pix_t       quot_r_l,
  input  csb_pkg::pix_t       quot_g_l,
  input  csb_pkg::pix_t       quot_b_l,
  output logic                ack,
  output logic                out_valid,
  input  logic                out_stall,
  output csb_pkg::pix_t       out_red_out,
  output csb_pkg::pix_t       out_green_out,
  output csb_pkg::pix_t       out_blue_out
);

  logic          vld_r, vld_nxt;
  csb_pkg::pix_t red_r, grn_r, blu_r;

  assign ack = stat_r_l.done && stat_g_l.done && stat_b_l.done && (!vld_r || !out_stall);

  always_comb begin
    vld_nxt = vld_r;
    if (ack) begin
      vld_nxt = 1'b1;
    end else if (vld_r && !out_stall) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ack) begin
      red_r <= quot_r_l;
      grn_r <= quot_g_l;
      blu_r <= quot_b_l;
    end
  end

  assign out_valid     = vld_r;
  assign out_red_out   = red_r;
  assign out_green_out = grn_r;
  assign out_blue_out  = blu_r;

endmodule

### rtl/rgb_contrast_stretch.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rgb_contrast_stretch
// Per-channel min-max contrast stretch of RGB pixels.
// ---------------------------------------------------------------------------
// A measure request (func 0) folds the pixel into the per-channel minimum and
// maximum (first_pixel reloads all of them) and gives no result.
// An apply request (func 1) returns (value - min) * 255 / (max - min) per
// channel, with value clamped to min..max, and 0 for a channel whose range
// is zero. Red, green and blue each have their own lane; the lane dividers
// produce one quotient bit per cycle: an apply loads the operands at
// acceptance, runs 8 divide steps, then hands the result to the output
// register in the same cycle as the next request can be taken.
// Results wait in the output register under out_stall without blocking the
// next request; an apply that finishes while a result still waits there holds
// the input stalled until that result drains.
// ---------------------------------------------------------------------------
module rgb_contrast_stretch (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic          in_func,
  input  logic          in_first_pixel,
  input  csb_pkg::pix_t in_red_in,
  input  csb_pkg::pix_t in_green_in,
  input  csb_pkg::pix_t in_blue_in,
  output logic          out_valid,
  input  logic          out_stall,
  output csb_pkg::pix_t out_red_out,
  output csb_pkg::pix_t out_green_out,
  output csb_pkg::pix_t out_blue_out
);

  csb_pkg::lane_stat_t stat_r_l, stat_g_l, stat_b_l;
  csb_pkg::pix_t       quot_r_l, quot_g_l, quot_b_l;
  logic                ack;
  logic                acc;
  logic                do_measure;
  logic                do_apply;

  assign in_stall   = (stat_r_l.busy || stat_g_l.busy || stat_b_l.busy) && !ack;
  assign acc        = in_valid && !in_stall;
  assign do_measure = acc && (in_func == csb_pkg::FUNC_MEASURE);
  assign do_apply   = acc && (in_func == csb_pkg::FUNC_APPLY);

  csb_lane u_lane_r (
    .clk     (clk),
    .rst_n   (rst_n),
    .measure (do_measure),
    .first   (in_first_pixel),
    .start   (do_apply),
    .ack     (ack),
    .pix     (in_red_in),
    .stat    (stat_r_l),
    .quot    (quot_r_l)
  );

  csb_lane u_lane_g (
    .clk     (clk),
    .rst_n   (rst_n),
    .measure (do_measure),
    .first   (in_first_pixel),
    .start   (do_apply),
    .ack     (ack),
    .pix     (in_green_in),
    .stat    (stat_g_l),
    .quot    (quot_g_l)
  );

  csb_lane u_lane_b (
    .clk     (clk),
    .rst_n   (rst_n),
    .measure (do_measure),
    .first   (in_first_pixel),
    .start   (do_apply),
    .ack     (ack),
    .pix     (in_blue_in),
    .stat    (stat_b_l),
    .quot    (quot_b_l)
  );

  csb_merge u_merge (
    .clk           (clk),
    .rst_n         (rst_n),
    .stat_r_l      (stat_r_l),
    .stat_g_l      (stat_g_l),
    .stat_b_l      (stat_b_l),
    .quot_r_l      (quot_r_l),
    .quot_g_l      (quot_g_l),
    .quot_b_l      (quot_b_l),
    .ack           (ack),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_red_out   (out_red_out),
    .out_green_out (out_green_out),
    .out_blue_out  (out_blue_out)
  );

endmodule
